[hdl/preemptive_priority_scheduler_macros.svh]
// Assertion macros for the preemptive priority scheduler.
// Used by the RTL module in this folder; no other dependencies.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`ifndef ASSERT_OFF
// Implication that must hold at every clock edge outside reset
`define PPS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true outside reset
`define PPS_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PPS_ASSERT(lbl, clk, rst_n, prop, msg)
`define PPS_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

[hdl/ppsched_pkg.sv]
// Package for the preemptive priority scheduler: table size, entry layout,
// codes and controller states. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ppsched_pkg;

	localparam int ENTRIES = 16;
	localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	localparam logic        OP_LOAD = 1'b0;
	localparam logic        OP_TICK = 1'b1;
	localparam logic [8:0]  MARK_IDLE = 9'h100;
	localparam logic [8:0]  MARK_NONE = 9'h1FF;
	localparam logic [31:0] TIME_MAX  = 32'hFFFF_FFFF;
	localparam logic [4:0]  ACTIVE_RESET = 5'd16;

	typedef struct packed {
		logic [7:0]  task_id;
		logic [15:0] arrival;
		logic [15:0] remaining;
		logic [7:0]  prio;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

[hdl/preemptive_priority_scheduler.sv]
// Preemptive priority scheduler: task table memory, slot scan and result register.
// Depends on ppsched_pkg and preemptive_priority_scheduler_macros.svh.
//
// Usage:
//   Input channel (in_valid / in_stall) carries load and tick beats. A load
//   writes one table slot. A tick scans the slots in use, one slot per
//   cycle through the table memory's single read port, picks the most
//   urgent arrived task, charges it one unit and emits one result beat.
//   n is the number of slots in use (min(active_count, 16)); with n = 0 the
//   tick skips the scan. Loads produce no result. in_stall is high while a
//   tick is being worked on.
//   Output channel (out_valid / out_stall) is fed from a result register, so
//   the next beat is accepted while a result still waits; a tick only stalls
//   at its end when the previous result has not been taken yet.
//   cfg_wr_en writes active_count from cfg_wr_data; write it only while no
//   tick is in flight.
//   Reset: all slots read as finished (no work), time is zero, active_count
//   is 16, and the first tick always opens a new segment.
`timescale 1ns / 1ps
`default_nettype none
`include "preemptive_priority_scheduler_macros.svh"
module preemptive_priority_scheduler (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_wr_en,
	input  wire logic [4:0]  cfg_wr_data,
	// input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        op,
	input  wire logic [3:0]  slot,
	input  wire logic [7:0]  task_id,
	input  wire logic [15:0] arrival,
	input  wire logic [15:0] burst,
	input  wire logic [7:0]  prio,
	// output channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      tick_time,
	output logic             idle,
	output logic [7:0]       run_id,
	output logic             new_segment,
	output logic             finished,
	output logic [31:0]      finish_time,
	output logic             all_done
);
	import ppsched_pkg::*;

	// table memory and per-slot valid bits
	entry_t              mem [ENTRIES];
	logic [ENTRIES-1:0]  valid_q;

	state_t              state_q, state_d;
	logic [4:0]          active_q;
	logic [31:0]         now_q;
	logic [8:0]          last_q;
	logic [SLOT_W-1:0]   idx_q;

	// read stage
	entry_t              rd_s1;
	logic                rd_vld_s1;
	logic                vbit_s1;
	logic [SLOT_W-1:0]   slot_s1;

	// scan accumulators
	logic                found_q;
	logic [CNT_W-1:0]    nz_q;
	logic [SLOT_W-1:0]   best_slot_q;
	entry_t              best_q;

	// result register
	logic                out_valid_q;
	logic [31:0]         tick_time_q, finish_time_q;
	logic                idle_q, new_segment_q, finished_q, all_done_q;
	logic [7:0]          run_id_q;

	logic                in_acc, tick_acc, load_acc, load_ok;
	logic [CNT_W-1:0]    n_use;
	logic                scan_last, out_free, done_go;
	logic                mem_we, rd_en;
	logic [SLOT_W-1:0]   mem_waddr;
	entry_t              mem_wdata, dec_ent;
	logic                ent_live, eligible, take;
	logic [8:0]          runner;
	logic                fin;
	logic [31:0]         now_inc;
	logic                done_all;

	// handshake decode
	assign in_acc   = in_valid && !in_stall;
	assign tick_acc = in_acc && (op == OP_TICK);
	assign load_acc = in_acc && (op == OP_LOAD);
	assign load_ok  = 32'(slot) < ENTRIES;
	assign out_free = !out_valid_q || !out_stall;
	assign done_go  = (state_q == ST_DONE) && out_free;

	// clamp slots in use to the table size
	assign n_use     = (32'(active_q) > ENTRIES) ? CNT_W'(ENTRIES) : CNT_W'(active_q);
	assign scan_last = (32'(idx_q) == (32'(n_use) - 32'd1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (tick_acc) begin
					state_d = (n_use == '0) ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_DONE;
			ST_DONE: begin
				if (done_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// controller outputs: stall, read issue and memory write selection
	always_comb begin
		dec_ent           = best_q;
		dec_ent.remaining = best_q.remaining - 16'd1;
		in_stall  = (state_q != ST_IDLE);
		rd_en     = (state_q == ST_SCAN);
		mem_we    = 1'b0;
		mem_waddr = best_slot_q;
		mem_wdata = dec_ent;
		if (load_acc) begin
			mem_we    = load_ok;
			mem_waddr = SLOT_W'(slot);
			mem_wdata = '{task_id: task_id, arrival: arrival, remaining: burst, prio: prio};
		end else if (done_go && found_q) begin
			mem_we = 1'b1;
		end
	end

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_s1 <= mem[idx_q];
		end
		slot_s1 <= idx_q;
		vbit_s1 <= valid_q[idx_q];
	end

	// valid bits, scan index, read stage valid, config and time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			active_q  <= ACTIVE_RESET;
			now_q     <= '0;
			last_q    <= MARK_NONE;
		end else begin
			if (mem_we) begin
				valid_q[mem_waddr] <= 1'b1;
			end
			if (tick_acc) begin
				idx_q <= '0;
			end else if (rd_en) begin
				idx_q <= idx_q + SLOT_W'(1);
			end
			rd_vld_s1 <= rd_en;
			if (cfg_wr_en) begin
				active_q <= cfg_wr_data;
			end
			if (done_go) begin
				now_q  <= now_inc;
				last_q <= runner;
			end
		end
	end

	// evaluate the slot read last cycle
	assign ent_live = vbit_s1 && (rd_s1.remaining != 16'd0);
	assign eligible = ent_live && ({16'd0, rd_s1.arrival} <= now_q);
	assign take     = eligible && (!found_q || (rd_s1.prio < best_q.prio));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			nz_q    <= '0;
		end else if (tick_acc) begin
			found_q <= 1'b0;
			nz_q    <= '0;
		end else if (rd_vld_s1) begin
			if (ent_live) begin
				nz_q <= nz_q + CNT_W'(1);
			end
			if (take) begin
				found_q <= 1'b1;
			end
		end
	end

	// hold the current best candidate
	always_ff @(posedge clk) begin
		if (rd_vld_s1 && take) begin
			best_slot_q <= slot_s1;
			best_q      <= rd_s1;
		end
	end

	// result of the tick
	assign runner   = found_q ? {1'b0, best_q.task_id} : MARK_IDLE;
	assign fin      = found_q && (best_q.remaining == 16'd1);
	assign now_inc  = (now_q == TIME_MAX) ? TIME_MAX : now_q + 32'd1;
	assign done_all = ((nz_q - CNT_W'(fin)) == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// load the result register
	always_ff @(posedge clk) begin
		if (done_go) begin
			tick_time_q   <= now_q;
			idle_q        <= !found_q;
			run_id_q      <= found_q ? best_q.task_id : 8'd0;
			new_segment_q <= (runner != last_q);
			finished_q    <= fin;
			finish_time_q <= fin ? now_inc : 32'd0;
			all_done_q    <= done_all;
		end
	end

	assign out_valid   = out_valid_q;
	assign tick_time   = tick_time_q;
	assign idle        = idle_q;
	assign run_id      = run_id_q;
	assign new_segment = new_segment_q;
	assign finished    = finished_q;
	assign finish_time = finish_time_q;
	assign all_done    = all_done_q;

	// checks
	`PPS_NEVER(a_scan_in_range, clk, arst_n, (state_q == ST_SCAN) && (32'(idx_q) >= 32'(n_use)), "scan index beyond slots in use")
	`PPS_ASSERT(a_tick_starts, clk, arst_n, tick_acc |=> (state_q == ST_SCAN) || (state_q == ST_DONE), "tick did not start a scan")
	`PPS_ASSERT(a_time_advance, clk, arst_n, done_go |=> (now_q == TIME_MAX) || (now_q == $past(now_q) + 32'd1), "time did not advance by one")
	`PPS_NEVER(a_fin_not_idle, clk, arst_n, out_valid_q && finished_q && idle_q, "finish reported on an idle tick")
	`PPS_ASSERT(a_best_in_range, clk, arst_n, (state_q == ST_DONE) && found_q |-> 32'(best_slot_q) < 32'(n_use), "selected slot not in use")

endmodule
`default_nettype wire

[tb/sv/tb_preemptive_priority_scheduler.sv]
`timescale 1ns / 1ps
// Self-checking bench for the preemptive priority scheduler: directed and random
// load/tick beats, predicted per tick and checked field by field. Depends on ppsched_pkg.
module tb_preemptive_priority_scheduler;
	import ppsched_pkg::*;

	localparam int STUCK_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 24;

	typedef struct packed {
		logic [31:0] tick_time;
		logic        idle;
		logic [7:0]  run_id;
		logic        new_segment;
		logic        finished;
		logic [31:0] finish_time;
		logic        all_done;
	} tick_report_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [4:0]  cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	logic        op;
	logic [3:0]  slot;
	logic [7:0]  task_id;
	logic [15:0] arrival;
	logic [15:0] burst;
	logic [7:0]  prio;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] tick_time;
	logic        idle;
	logic [7:0]  run_id;
	logic        new_segment;
	logic        finished;
	logic [31:0] finish_time;
	logic        all_done;

	// scheduler image kept by the bench
	logic [7:0]  tbl_id     [ENTRIES];
	logic [15:0] tbl_arrival[ENTRIES];
	logic [15:0] tbl_left   [ENTRIES];
	logic [7:0]  tbl_prio   [ENTRIES];
	logic [31:0] sim_now;
	logic [8:0]  prev_runner;
	logic [4:0]  active_cfg;

	tick_report_t expected_ticks[$];
	int errors       = 0;
	int stuck_cycles = 0;
	int items_sent   = 0;
	int tx_gap_pct   = 0;
	int rx_stall_pct = 0;

	preemptive_priority_scheduler u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .slot(slot), .task_id(task_id), .arrival(arrival),
		.burst(burst), .prio(prio),
		.out_valid(out_valid), .out_stall(out_stall),
		.tick_time(tick_time), .idle(idle), .run_id(run_id),
		.new_segment(new_segment), .finished(finished),
		.finish_time(finish_time), .all_done(all_done)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Receiver backpressure, changed on the falling edge
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < rx_stall_pct);
	end

	// Predict one tick: pick the most urgent arrived task, charge it one unit
	task automatic schedule_tick();
		tick_report_t r;
		int unsigned  used;
		int           sel;
		logic [7:0]   best;
		logic [8:0]   runner;
		used = (active_cfg > ENTRIES) ? ENTRIES : active_cfg;
		sel = -1;
		best = '0;
		r = '0;
		r.tick_time = sim_now;
		for (int i = 0; i < used; i++) begin
			if (32'(tbl_arrival[i]) <= sim_now && tbl_left[i] != 0 &&
			    (sel < 0 || tbl_prio[i] < best)) begin
				best = tbl_prio[i];
				sel = i;
			end
		end
		if (sel < 0) begin
			r.idle = 1'b1;
			runner = MARK_IDLE;
		end else begin
			r.run_id = tbl_id[sel];
			runner = {1'b0, tbl_id[sel]};
			tbl_left[sel] = tbl_left[sel] - 16'd1;
			if (tbl_left[sel] == 0) begin
				r.finished = 1'b1;
				r.finish_time = (sim_now == TIME_MAX) ? TIME_MAX : sim_now + 32'd1;
			end
		end
		r.all_done = 1'b1;
		for (int i = 0; i < used; i++)
			if (tbl_left[i] != 0)
				r.all_done = 1'b0;
		r.new_segment = (runner != prev_runner);
		prev_runner = runner;
		sim_now = (sim_now == TIME_MAX) ? TIME_MAX : sim_now + 32'd1;
		expected_ticks.push_back(r);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
	                           input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	// Track accepted beats on both channels and check each result
	always @(posedge clk) begin
		tick_report_t want;
		logic moved;
		if (!arst_n) begin
			// clear the bench image while in reset
			for (int i = 0; i < ENTRIES; i++) begin
				tbl_id[i] = '0;
				tbl_arrival[i] = '0;
				tbl_left[i] = '0;
				tbl_prio[i] = '0;
			end
			sim_now = '0;
			prev_runner = MARK_NONE;
			active_cfg = ACTIVE_RESET;
		end else begin
			moved = 1'b0;
			if (cfg_wr_en)
				active_cfg = cfg_wr_data;
			if (in_valid && !in_stall) begin
				moved = 1'b1;
				if (op == OP_TICK) begin
					schedule_tick();
				end else begin
					tbl_id[slot] = task_id;
					tbl_arrival[slot] = arrival;
					tbl_left[slot] = burst;
					tbl_prio[slot] = prio;
				end
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				if (expected_ticks.size() == 0) begin
					errors++;
					$display("%0t: result beat with no tick pending", $time);
				end else begin
					want = expected_ticks.pop_front();
					check_field("tick_time", want.tick_time, tick_time);
					check_field("idle", 32'(want.idle), 32'(idle));
					check_field("run_id", 32'(want.run_id), 32'(run_id));
					check_field("new_segment", 32'(want.new_segment), 32'(new_segment));
					check_field("finished", 32'(want.finished), 32'(finished));
					check_field("finish_time", want.finish_time, finish_time);
					check_field("all_done", 32'(want.all_done), 32'(all_done));
				end
			end
			stuck_cycles = moved ? 0 : stuck_cycles + 1;
		end
	end

	initial begin
		wait (stuck_cycles >= STUCK_LIMIT);
		$display("FAILURE");
		$finish;
	end

	// Drive one beat from a falling edge and hold it until accepted
	task automatic send_beat(input logic op_i, input logic [3:0] slot_i,
	                         input logic [7:0] id_i, input logic [15:0] arr_i,
	                         input logic [15:0] burst_i, input logic [7:0] prio_i);
		if ($urandom_range(99) < tx_gap_pct) begin
			in_valid = 1'b0;
			repeat ($urandom_range(3, 1)) @(negedge clk);
		end
		in_valid = 1'b1;
		op = op_i;
		slot = slot_i;
		task_id = id_i;
		arrival = arr_i;
		burst = burst_i;
		prio = prio_i;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic load_task(input logic [3:0] s, input logic [7:0] id,
	                         input logic [15:0] arr, input logic [15:0] work,
	                         input logic [7:0] p);
		send_beat(OP_LOAD, s, id, arr, work, p);
	endtask

	// Tick beats carry junk in the load fields
	task automatic tick();
		send_beat(OP_TICK, 4'($urandom), 8'($urandom), 16'($urandom),
		          16'($urandom), 8'($urandom));
	endtask

	// Hold off until every tick has reported and the block is quiet
	task automatic settle();
		in_valid = 1'b0;
		while (expected_ticks.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_active(input logic [4:0] v);
		settle();
		cfg_wr_en = 1'b1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// Empty table after reset: idle ticks, first one opens a segment
	task automatic test_idle_after_reset();
		tick();
		tick();
	endtask

	// Ties, zero bursts, id zero, far arrival, same id after idle
	task automatic test_directed_table();
		load_task(4'd0, 8'd7, 16'd0, 16'd2, 8'd5);
		load_task(4'd15, 8'd255, 16'hFFFF, 16'hFFFF, 8'd255);
		load_task(4'd1, 8'd0, 16'd0, 16'd1, 8'd0);
		load_task(4'd2, 8'd9, 16'd0, 16'd1, 8'd0);
		load_task(4'd3, 8'd3, 16'd0, 16'd0, 8'd0);
		tick();
		tick();
		load_task(4'd4, 8'd20, 16'd5, 16'd2, 8'd1);
		tick();
		tick();
		tick();
		tick();
		tick();
		tick();
		load_task(4'd5, 8'd7, 16'd0, 16'd1, 8'd255);
		tick();
		load_task(4'd15, 8'd255, 16'd0, 16'd0, 8'd255);
		tick();
	endtask

	// Slots in use: none, above the table, one, and the full table
	task automatic test_active_count();
		write_active(5'd0);
		tick();
		load_task(4'd0, 8'd1, 16'd0, 16'd1, 8'd0);
		tick();
		write_active(5'd31);
		tick();
		load_task(4'd15, 8'd44, 16'd0, 16'd2, 8'd0);
		tick();
		write_active(5'd1);
		load_task(4'd1, 8'd50, 16'd0, 16'd3, 8'd0);
		tick();
		write_active(5'd17);
		tick();
		write_active(5'd16);
		tick();
		tick();
		tick();
	endtask

	// Well-formed task near the current time with little work
	task automatic load_near_task(input logic [3:0] s, inout int work);
		logic [15:0] w;
		logic [7:0]  p;
		w = 16'($urandom_range(4));
		p = ($urandom_range(1) == 0) ? 8'($urandom_range(3)) : 8'($urandom);
		load_task(s, 8'($urandom), 16'(sim_now + $urandom_range(6)), w, p);
		work += w;
	endtask

	// One scenario: set the slot count, load most slots, tick up to 48 times
	task automatic run_scenario();
		logic [4:0] cnt;
		int used;
		int work;
		int ticks;
		case ($urandom_range(19))
			0: cnt = 5'd0;
			1: cnt = 5'($urandom_range(31, 17));
			default: cnt = 5'($urandom_range(16, 1));
		endcase
		write_active(cnt);
		used = (cnt > ENTRIES) ? ENTRIES : cnt;
		work = 0;
		for (int s = 0; s < used; s++)
			if ($urandom_range(9) != 0)
				load_near_task(4'(s), work);
		ticks = work + $urandom_range(4, 1);
		if (ticks > 48)
			ticks = 48;
		for (int k = 0; k < ticks; k++) begin
			if ($urandom_range(99) < 10 && used > 0)
				load_near_task(4'($urandom_range(used - 1)), work);
			if ($urandom_range(99) < 4)
				load_task(4'($urandom), 8'($urandom), 16'($urandom),
				          16'($urandom), 8'($urandom));
			tick();
		end
	endtask

	task automatic test_random_phase(input int gap_pct, input int stall_pct,
	                                 input int beats);
		int stop_at;
		tx_gap_pct = gap_pct;
		rx_stall_pct = stall_pct;
		stop_at = items_sent + beats;
		while (items_sent < stop_at)
			run_scenario();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		op = OP_LOAD;
		slot = '0;
		task_id = '0;
		arrival = '0;
		burst = '0;
		prio = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		test_idle_after_reset();
		test_directed_table();
		test_active_count();
		test_random_phase(12, 59, 175);
		test_random_phase(59, 12, 175);
		test_random_phase(0, 0, 175);
		settle();

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
